@@ rtl/core/rrg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_pkg: shared definitions for the rhythm resultant generator
// Register indexes, port widths and the layout of the result beat.
// ----------------------------------------------------------------------------
package rrg_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_MAJOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MINOR = 1'd1;

   // beat widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // result beat payload, lowest field last
   typedef struct packed {
      logic       pad;
      logic [7:0] cycle_length;
      logic [3:0] lane_count;
      logic [8:0] lane_mask;
      logic       major_bit;
      logic       resultant_bit;
      logic [7:0] step_index;
   } rsp_data_type;

endpackage

@@ rtl/core/rhythm_resultant_generator.sv @@
`timescale 1ns / 1ps
// Output: a result beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one beat per cycle while the result channel is not stalled; the step counter
// and phase counters advance with each accepted beat, and the result register frees as the next beat arrives.
// Reset: synchronous, active high; both generators return to 1, the cycle to
// step 0, and the result register empties.
// ----------------------------------------------------------------------------
// rhythm_resultant_generator
// Steps through the a*a + a*b cycle of a generator pair and gives the a-pulse,
// the b-lane attack mask and their resultant for each step.
// ----------------------------------------------------------------------------
module rhythm_resultant_generator #(
   parameter int MAX_GENERATOR = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rrg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] step_index, [8] resultant_bit, [9] major_bit, [18:10] lane_mask,
   // [22:19] lane_count, [30:23] cycle_length, [31] zero
   output logic [rrg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   // configuration port
   input  logic                             csr_we,
   input  logic [rrg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int GEN_W = $clog2(MAX_GENERATOR + 1);
   localparam int CNT_W = $clog2(2 * MAX_GENERATOR * MAX_GENERATOR + 1);
   localparam logic [rrg_pkg::CSR_DATA_W-1:0] GEN_MAX =
      rrg_pkg::CSR_DATA_W'(MAX_GENERATOR);
   localparam logic [rrg_pkg::CSR_DATA_W-1:0] GEN_ONE = rrg_pkg::CSR_DATA_W'(1);

   // registers
   logic [rrg_pkg::CSR_DATA_W-1:0] major_gen_ff, major_gen_in;
   logic [rrg_pkg::CSR_DATA_W-1:0] minor_gen_ff, minor_gen_in;
   logic [CNT_W-1:0]               step_ff, step_in;
   logic [GEN_W-1:0]               major_phase_ff, major_phase_in;
   logic [GEN_W-1:0]               minor_phase_ff, minor_phase_in;
   logic [GEN_W-1:0]               lane_phase_ff [MAX_GENERATOR];
   logic [GEN_W-1:0]               lane_phase_in [MAX_GENERATOR];
   logic                           rsp_valid_ff, rsp_valid_in;
   rrg_pkg::rsp_data_type          rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   // derived generator values
   logic [rrg_pkg::CSR_DATA_W-1:0] gen_a4, gen_b4;
   logic [GEN_W-1:0]               gen_a, gen_b, lanes;
   logic [CNT_W-1:0]               sq, ab, len;

   // step logic
   logic                           req_fire;
   logic                           restart_eff;
   logic [CNT_W-1:0]               step_cur, step_inc;
   logic                           at_end;
   logic [GEN_W-1:0]               major_cur, minor_cur;
   logic [GEN_W-1:0]               lane_cur  [MAX_GENERATOR];
   logic [CNT_W-1:0]               lane_off  [MAX_GENERATOR];
   logic                           lane_past [MAX_GENERATOR];
   logic [MAX_GENERATOR-1:0]       mask;
   logic                           major_hit;
   logic                           fill_hit;

   // clamp generators: a to 1..MAX, b to 1..a
   always_comb begin
      if (major_gen_ff == '0) begin
         gen_a4 = GEN_ONE;
      end else if (major_gen_ff > GEN_MAX) begin
         gen_a4 = GEN_MAX;
      end else begin
         gen_a4 = major_gen_ff;
      end
      if (minor_gen_ff == '0) begin
         gen_b4 = GEN_ONE;
      end else if (minor_gen_ff > gen_a4) begin
         gen_b4 = gen_a4;
      end else begin
         gen_b4 = minor_gen_ff;
      end
      gen_a = GEN_W'(gen_a4);
      gen_b = GEN_W'(gen_b4);
      lanes = gen_a - gen_b + GEN_W'(1);
      sq    = CNT_W'(gen_a) * CNT_W'(gen_a);
      ab    = CNT_W'(gen_a) * CNT_W'(gen_b);
      len   = sq + ab;
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // current step and its attacks
   always_comb begin
      restart_eff = req_tdata[0] || (step_ff >= len);
      step_cur    = restart_eff ? '0 : step_ff;
      major_cur   = restart_eff ? '0 : major_phase_ff;
      minor_cur   = restart_eff ? '0 : minor_phase_ff;
      step_inc    = step_cur + CNT_W'(1);
      at_end      = (step_inc >= len);
      major_hit   = (major_cur == '0);
      fill_hit    = (step_cur >= sq) && (minor_cur == '0);
      mask        = '0;
      for (int j = 0; j < MAX_GENERATOR; j++) begin
         lane_cur[j]  = restart_eff ? '0 : lane_phase_ff[j];
         lane_off[j]  = CNT_W'(j) * CNT_W'(gen_a);
         lane_past[j] = (step_cur >= lane_off[j]);
         if (GEN_W'(j) < lanes) begin
            // lane j attacks every b steps over its a*b span
            if (lane_past[j] && (step_cur < lane_off[j] + ab) && (lane_cur[j] == '0)) begin
               mask[j] = 1'b1;
            end
            // tail of the cycle: all lanes together every b steps
            if (fill_hit) begin
               mask[j] = 1'b1;
            end
         end
      end
   end

   // next state of the counters
   always_comb begin
      step_in        = step_ff;
      major_phase_in = major_phase_ff;
      minor_phase_in = minor_phase_ff;
      major_gen_in   = major_gen_ff;
      minor_gen_in   = minor_gen_ff;
      for (int j = 0; j < MAX_GENERATOR; j++) begin
         lane_phase_in[j] = lane_phase_ff[j];
      end
      if (csr_we) begin
         unique case (csr_index)
            rrg_pkg::REG_MAJOR: major_gen_in = csr_wdata;
            rrg_pkg::REG_MINOR: minor_gen_in = csr_wdata;
            default:            ;
         endcase
         step_in        = '0;
         major_phase_in = '0;
         minor_phase_in = '0;
         for (int j = 0; j < MAX_GENERATOR; j++) begin
            lane_phase_in[j] = '0;
         end
      end else if (req_fire) begin
         if (at_end) begin
            step_in        = '0;
            major_phase_in = '0;
            minor_phase_in = '0;
            for (int j = 0; j < MAX_GENERATOR; j++) begin
               lane_phase_in[j] = '0;
            end
         end else begin
            step_in        = step_inc;
            major_phase_in = (major_cur + GEN_W'(1) >= gen_a) ? '0 : major_cur + GEN_W'(1);
            if (step_cur >= sq) begin
               minor_phase_in = (minor_cur + GEN_W'(1) >= gen_b) ? '0 : minor_cur + GEN_W'(1);
            end else begin
               minor_phase_in = '0;
            end
            for (int j = 0; j < MAX_GENERATOR; j++) begin
               if (lane_past[j]) begin
                  lane_phase_in[j] = (lane_cur[j] + GEN_W'(1) >= gen_b) ? '0
                                   : lane_cur[j] + GEN_W'(1);
               end else begin
                  lane_phase_in[j] = '0;
               end
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_tready) begin
         rsp_valid_in = req_tvalid;
      end
      if (req_fire) begin
         rsp_data_in.pad           = 1'b0;
         rsp_data_in.cycle_length  = 8'(len);
         rsp_data_in.lane_count    = 4'(lanes);
         rsp_data_in.lane_mask     = 9'(mask);
         rsp_data_in.major_bit     = major_hit;
         rsp_data_in.resultant_bit = major_hit || (mask != '0);
         rsp_data_in.step_index    = 8'(step_cur);
         rsp_last_in               = (step_inc == len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_gen_ff   <= GEN_ONE;
         minor_gen_ff   <= GEN_ONE;
         step_ff        <= '0;
         major_phase_ff <= '0;
         minor_phase_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int j = 0; j < MAX_GENERATOR; j++) begin
            lane_phase_ff[j] <= '0;
         end
      end else begin
         major_gen_ff   <= major_gen_in;
         minor_gen_ff   <= minor_gen_in;
         step_ff        <= step_in;
         major_phase_ff <= major_phase_in;
         minor_phase_ff <= minor_phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int j = 0; j < MAX_GENERATOR; j++) begin
            lane_phase_ff[j] <= lane_phase_in[j];
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/core/rrg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_checker: port-level checks for the rhythm resultant generator
// Watches the request and result channels and the result beat contents.
// ----------------------------------------------------------------------------
module rrg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rrg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   rrg_pkg::rsp_data_type beat;

   assign beat = rsp_tdata;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // every accepted request beat shows up as a result beat next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result beat");

   // resultant is the OR of the a-pulse and all lanes
   a_resultant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> beat.resultant_bit == (beat.major_bit || (beat.lane_mask != '0)))
      else $error("resultant does not match pulse and lanes");

   // no lane above the lane count attacks
   a_lane_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (beat.lane_mask >> beat.lane_count) == '0)
      else $error("lane attack beyond lane count");

endmodule

bind rhythm_resultant_generator rrg_checker u_rrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/rrg_step_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_step_checker
// Watches the request, result and configuration ports of the rhythm resultant
// generator and keeps its own model of the step sequencer. Every accepted
// request beat queues the step that the block should return. Every accepted
// result beat is compared field by field against the oldest queued step.
// ----------------------------------------------------------------------------
module rrg_step_checker #(
   parameter int MAX_GENERATOR = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rrg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] step_index, [8] resultant_bit, [9] major_bit, [18:10] lane_mask,
   // [22:19] lane_count, [30:23] cycle_length, [31] zero
   input  logic [rrg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [rrg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   typedef struct {
      rrg_pkg::rsp_data_type data;
      logic                  last;
   } step_beat_type;

   // steps predicted but not yet returned, oldest first
   step_beat_type expected_steps[$];

   // model state
   logic [3:0]  major_gen;
   logic [3:0]  minor_gen;
   int unsigned step_count;
   int unsigned major_phase;
   int unsigned minor_phase;

   task automatic clear_cycle();
      step_count  = 0;
      major_phase = 0;
      minor_phase = 0;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // work out the step the block returns for one request beat, then advance
   task automatic predict_step(input logic restart);
      int unsigned   a;
      int unsigned   b;
      int unsigned   sq;
      int unsigned   ab;
      int unsigned   len;
      int unsigned   lanes;
      int unsigned   step;
      int unsigned   off;
      int unsigned   mask;
      logic          major;
      step_beat_type beat;

      // clamp the generators: a to 1..MAX_GENERATOR, b to 1..a
      a = major_gen;
      if (a < 1) a = 1;
      if (a > MAX_GENERATOR) a = MAX_GENERATOR;
      b = minor_gen;
      if (b < 1) b = 1;
      if (b > a) b = a;
      sq    = a * a;
      ab    = a * b;
      len   = sq + ab;
      lanes = a - b + 1;

      if (restart || step_count >= len) clear_cycle();
      step  = step_count;
      major = (major_phase == 0);

      // lane j attacks every b steps inside its window of a*b starting at j*a
      mask = 0;
      for (int j = 0; j < lanes; j++) begin
         off = j * a;
         if (step >= off && (step - off) < ab && ((step - off) % b) == 0)
            mask |= (1 << j);
      end
      // tail of the cycle: all lanes strike together every b steps
      if (step >= sq && minor_phase == 0) mask |= (1 << lanes) - 1;

      beat.data.pad           = 1'b0;
      beat.data.step_index    = 8'(step);
      beat.data.resultant_bit = major || (mask != 0);
      beat.data.major_bit     = major;
      beat.data.lane_mask     = 9'(mask);
      beat.data.lane_count    = 4'(lanes);
      beat.data.cycle_length  = 8'(len);
      beat.last               = (step + 1 == len);
      expected_steps.push_back(beat);

      if (step + 1 >= len) begin
         clear_cycle();
      end else begin
         step_count  = step + 1;
         major_phase = (major_phase + 1 >= a) ? 0 : major_phase + 1;
         if (step_count > sq)
            minor_phase = (minor_phase + 1 >= b) ? 0 : minor_phase + 1;
         else
            minor_phase = 0;
      end
   endtask

   always @(posedge clock) begin
      rrg_pkg::rsp_data_type got;
      step_beat_type         want;

      if (reset) begin
         major_gen = 4'd1;
         minor_gen = 4'd1;
         clear_cycle();
         expected_steps.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rrg_pkg::rsp_data_type'(rsp_tdata);
            if (expected_steps.size() == 0) begin
               $display("%0t: result beat with none expected, expected none, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_steps.pop_front();
               check_field("step_index", want.data.step_index, got.step_index);
               check_field("resultant_bit", want.data.resultant_bit, got.resultant_bit);
               check_field("major_bit", want.data.major_bit, got.major_bit);
               check_field("lane_mask", want.data.lane_mask, got.lane_mask);
               check_field("lane_count", want.data.lane_count, got.lane_count);
               check_field("cycle_length", want.data.cycle_length, got.cycle_length);
               check_field("pad", want.data.pad, got.pad);
               check_field("last", want.last, rsp_tlast);
            end
         end

         // register writes restart the cycle
         if (csr_we) begin
            case (csr_index)
               rrg_pkg::REG_MAJOR: begin
                  major_gen = csr_wdata;
                  clear_cycle();
               end
               rrg_pkg::REG_MINOR: begin
                  minor_gen = csr_wdata;
                  clear_cycle();
               end
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) predict_step(req_tdata[0]);
      end
      pending = expected_steps.size();
   end

endmodule

@@ tb/rhythm_resultant_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhythm_resultant_generator_test
// Drives the rhythm resultant generator with directed steps at the generator
// extremes, then long runs over fixed and random generator pairs with sparse
// restarts and random gaps on both channels. A checker beside the block
// predicts every step; this module gives the verdict.
// ----------------------------------------------------------------------------
module rhythm_resultant_generator_test;

   localparam int MAX_GENERATOR = 9;
   localparam int ITEM_TARGET   = 600;
   localparam int STALL_LIMIT   = 500;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rrg_pkg::REQ_DATA_W-1:0]   req_tdata;   // [0] restart
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // [7:0] step_index, [8] resultant_bit, [9] major_bit, [18:10] lane_mask,
   // [22:19] lane_count, [30:23] cycle_length, [31] zero
   logic [rrg_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_we;
   logic [rrg_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [rrg_pkg::CSR_DATA_W-1:0]   csr_wdata;

   int          fail_count;
   int          pending;
   int unsigned items_sent;
   int unsigned stall_cycles;
   logic        quiet;      // no gaps on either side while set

   rhythm_resultant_generator #(
      .MAX_GENERATOR (MAX_GENERATOR)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rrg_step_checker #(
      .MAX_GENERATOR (MAX_GENERATOR)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned draw_gap();
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   // one request beat; tvalid stays high afterwards unless the next gap drops it
   task automatic send_step(input logic restart);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rrg_pkg::REQ_DATA_W-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop sending and hold off until every predicted step has come back
   task automatic drain_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_generator(input logic [rrg_pkg::CSR_IDX_W-1:0] idx,
                                  input logic [rrg_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stalls between beats
   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned count;
      int unsigned mode;
      logic [3:0]  a_val;
      logic [3:0]  b_val;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      quiet        = 1'b0;
      items_sent   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values a = b = 1, restart on the first beat
      send_step(1'b1);
      repeat (3) send_step(1'b0);
      drain_results();

      // zero generators act as 1
      write_generator(rrg_pkg::REG_MAJOR, 4'd0);
      write_generator(rrg_pkg::REG_MINOR, 4'd0);
      repeat (2) send_step(1'b0);
      send_step(1'b1);
      drain_results();

      // oversized generators clamp to the maximum
      write_generator(rrg_pkg::REG_MAJOR, 4'd15);
      write_generator(rrg_pkg::REG_MINOR, 4'd15);
      repeat (3) send_step(1'b0);
      send_step(1'b1);
      send_step(1'b0);
      drain_results();

      // minor above major acts as major
      write_generator(rrg_pkg::REG_MAJOR, 4'd4);
      write_generator(rrg_pkg::REG_MINOR, 4'd7);
      repeat (4) send_step(1'b0);
      drain_results();

      write_generator(rrg_pkg::REG_MAJOR, 4'd3);
      write_generator(rrg_pkg::REG_MINOR, 4'd1);
      repeat (5) send_step(1'b0);
      drain_results();

      // random runs; the first two use the fixed pairs a = b = 9 and a = 9, b = 1
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         mode = 0;
         if (phase == 0) begin
            a_val = 4'd9;
            b_val = 4'd9;
            count = 170;
         end else if (phase == 1) begin
            a_val = 4'd9;
            b_val = 4'd1;
            count = 100;
         end else begin
            a_val = 4'($urandom_range(0, 15));
            b_val = 4'($urandom_range(0, 15));
            mode  = $urandom_range(0, 2);
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 175)
                                                : $urandom_range(8, 60);
         end
         // keep the total near the target
         if (count > ITEM_TARGET - items_sent) count = ITEM_TARGET - items_sent;
         quiet = ($urandom_range(0, 3) == 0);
         if (mode != 2) write_generator(rrg_pkg::REG_MAJOR, a_val);
         if (mode != 1) write_generator(rrg_pkg::REG_MINOR, b_val);
         repeat (count) send_step($urandom_range(0, 39) == 0);
         drain_results();
         phase++;
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rrg_pkg.sv
rtl/core/rhythm_resultant_generator.sv
rtl/core/rrg_checker.sv
tb/rrg_step_checker.sv
tb/rhythm_resultant_generator_test.sv
